// ===== hw/rtl/pidvs_pkg.sv =====
// Shared constants, microcode format and control program of the variable-step PID controller.
`default_nettype none
package pidvs_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int TIME_W     = 32;
   localparam int INTEG_W    = 48;
   localparam int MAG_W      = 64;
   localparam int DIGIT_W    = 16;
   localparam int NUM_DIGITS = MAG_W / DIGIT_W;
   localparam int PROD_W     = 2 * MAG_W;
   localparam int TERM_W     = 62;
   localparam int ACC_W      = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int STEP_W     = 5;

   localparam logic [PROD_W-1:0] TERM_LIM = PROD_W'(64'h1000_0000_0000_0000);

   localparam logic [CSR_IDX_W-1:0] REG_TARGET     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_PROP  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_INTEG = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_DERIV = 2'd3;

   localparam logic [3:0] OP_NOP     = 4'd0;
   localparam logic [3:0] OP_ERR     = 4'd1;
   localparam logic [3:0] OP_MUL_P   = 4'd2;
   localparam logic [3:0] OP_MUL_I   = 4'd3;
   localparam logic [3:0] OP_MUL_G   = 4'd4;
   localparam logic [3:0] OP_MUL_D   = 4'd5;
   localparam logic [3:0] OP_DIV     = 4'd6;
   localparam logic [3:0] OP_ACC_SET = 4'd7;
   localparam logic [3:0] OP_ACC_ADD = 4'd8;
   localparam logic [3:0] OP_INTEG   = 4'd9;
   localparam logic [3:0] OP_OUT     = 4'd10;

   localparam logic [2:0] COND_NEVER    = 3'd0;
   localparam logic [2:0] COND_ALWAYS   = 3'd1;
   localparam logic [2:0] COND_NO_REQ   = 3'd2;
   localparam logic [2:0] COND_MUL_BUSY = 3'd3;
   localparam logic [2:0] COND_DIV_BUSY = 3'd4;
   localparam logic [2:0] COND_DT_ZERO  = 3'd5;
   localparam logic [2:0] COND_RSP_BUSY = 3'd6;

   localparam logic [STEP_W-1:0] STEP_IDLE     = 5'd0;
   localparam logic [STEP_W-1:0] STEP_ERR      = 5'd1;
   localparam logic [STEP_W-1:0] STEP_MUL_P    = 5'd2;
   localparam logic [STEP_W-1:0] STEP_WAIT_P   = 5'd3;
   localparam logic [STEP_W-1:0] STEP_SUM_P    = 5'd4;
   localparam logic [STEP_W-1:0] STEP_DIV      = 5'd5;
   localparam logic [STEP_W-1:0] STEP_MUL_I    = 5'd6;
   localparam logic [STEP_W-1:0] STEP_WAIT_I   = 5'd7;
   localparam logic [STEP_W-1:0] STEP_INTEG    = 5'd8;
   localparam logic [STEP_W-1:0] STEP_MUL_G    = 5'd9;
   localparam logic [STEP_W-1:0] STEP_WAIT_G   = 5'd10;
   localparam logic [STEP_W-1:0] STEP_SUM_G    = 5'd11;
   localparam logic [STEP_W-1:0] STEP_WAIT_DIV = 5'd12;
   localparam logic [STEP_W-1:0] STEP_MUL_D    = 5'd13;
   localparam logic [STEP_W-1:0] STEP_WAIT_D   = 5'd14;
   localparam logic [STEP_W-1:0] STEP_SUM_D    = 5'd15;
   localparam logic [STEP_W-1:0] STEP_OUT      = 5'd16;
   localparam logic [STEP_W-1:0] STEP_LOOP     = 5'd17;

   typedef struct packed {
      logic [3:0]        op;
      logic [2:0]        cond;
      logic [STEP_W-1:0] target;
   } ucode_type;

   function automatic ucode_type uword(input logic [3:0] op, input logic [2:0] cond,
                                       input logic [STEP_W-1:0] target);
      ucode_type w;
      w.op     = op;
      w.cond   = cond;
      w.target = target;
      return w;
   endfunction

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      case (step)
         STEP_IDLE:     w = uword(OP_NOP,     COND_NO_REQ,   STEP_IDLE);
         STEP_ERR:      w = uword(OP_ERR,     COND_NEVER,    STEP_IDLE);
         STEP_MUL_P:    w = uword(OP_MUL_P,   COND_NEVER,    STEP_IDLE);
         STEP_WAIT_P:   w = uword(OP_NOP,     COND_MUL_BUSY, STEP_WAIT_P);
         STEP_SUM_P:    w = uword(OP_ACC_SET, COND_DT_ZERO,  STEP_OUT);
         STEP_DIV:      w = uword(OP_DIV,     COND_NEVER,    STEP_IDLE);
         STEP_MUL_I:    w = uword(OP_MUL_I,   COND_NEVER,    STEP_IDLE);
         STEP_WAIT_I:   w = uword(OP_NOP,     COND_MUL_BUSY, STEP_WAIT_I);
         STEP_INTEG:    w = uword(OP_INTEG,   COND_NEVER,    STEP_IDLE);
         STEP_MUL_G:    w = uword(OP_MUL_G,   COND_NEVER,    STEP_IDLE);
         STEP_WAIT_G:   w = uword(OP_NOP,     COND_MUL_BUSY, STEP_WAIT_G);
         STEP_SUM_G:    w = uword(OP_ACC_ADD, COND_NEVER,    STEP_IDLE);
         STEP_WAIT_DIV: w = uword(OP_NOP,     COND_DIV_BUSY, STEP_WAIT_DIV);
         STEP_MUL_D:    w = uword(OP_MUL_D,   COND_NEVER,    STEP_IDLE);
         STEP_WAIT_D:   w = uword(OP_NOP,     COND_MUL_BUSY, STEP_WAIT_D);
         STEP_SUM_D:    w = uword(OP_ACC_ADD, COND_NEVER,    STEP_IDLE);
         STEP_OUT:      w = uword(OP_OUT,     COND_RSP_BUSY, STEP_OUT);
         STEP_LOOP:     w = uword(OP_NOP,     COND_ALWAYS,   STEP_IDLE);
         default:       w = uword(OP_NOP,     COND_ALWAYS,   STEP_IDLE);
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pidvs_if.sv =====
// Request, response and register-write channel interfaces of the PID controller.
`default_nettype none
interface pidvs_req_if #(
   parameter int DATA_WIDTH = pidvs_pkg::DATA_WIDTH_DEF
);
   logic                              valid;
   logic                              ready;
   logic signed [DATA_WIDTH-1:0]      measured_value;
   logic [pidvs_pkg::TIME_W-1:0]      sample_time;

   modport source (output valid, measured_value, sample_time, input ready);
   modport sink (input valid, measured_value, sample_time, output ready);
endinterface

interface pidvs_rsp_if #(
   parameter int DATA_WIDTH = pidvs_pkg::DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] drive_value;
   logic signed [DATA_WIDTH-1:0] error_value;
   logic                         saturated_flag;

   modport source (output valid, drive_value, error_value, saturated_flag, input ready);
   modport sink (input valid, drive_value, error_value, saturated_flag, output ready);
endinterface

interface pidvs_csr_if #(
   parameter int DATA_WIDTH = pidvs_pkg::DATA_WIDTH_DEF
);
   logic                              valid;
   logic                              ready;
   logic [pidvs_pkg::CSR_IDX_W-1:0]   index;
   logic signed [DATA_WIDTH-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pid_controller_variable_step.sv =====
// Variable-step PID controller: microcoded sequencer over a shared multiplier and a divider.
//
// One response per request. A request carries a signed fixed-point measurement and a
// timestamp; the response gives the saturated drive, the saturated error and a clip flag.
// When the timestamp equals the previous one, the integral and derivative passes are skipped
// and the program goes from the proportional sum straight to its output step. The radix-2
// divider (one quotient bit per cycle) runs alongside the two integral passes, and the
// proportional and derivative passes go through the shared 64x16 multiplier, each followed
// by one step to add the term. A new request is taken as soon as the program returns to
// its first step, while the previous response may still wait on the response channel; a
// response still waiting holds the next request at its output step. Register writes are
// taken at any time and must only happen while the block is idle.
`default_nettype none
module pid_controller_variable_step #(
   parameter int DATA_WIDTH = pidvs_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = pidvs_pkg::FRAC_BITS_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   pidvs_req_if.sink     req_bus,
   pidvs_rsp_if.source   rsp_bus,
   pidvs_csr_if.sink     csr_bus
);

   localparam int DW      = DATA_WIDTH;
   localparam int TW      = pidvs_pkg::TIME_W;
   localparam int IW      = pidvs_pkg::INTEG_W;
   localparam int MW      = pidvs_pkg::MAG_W;
   localparam int GW      = pidvs_pkg::DIGIT_W;
   localparam int PW      = pidvs_pkg::PROD_W;
   localparam int XW      = pidvs_pkg::TERM_W;
   localparam int AW      = pidvs_pkg::ACC_W;
   localparam int SW      = pidvs_pkg::STEP_W;
   localparam int MCNT_W  = $clog2(pidvs_pkg::NUM_DIGITS + 1);
   localparam int DCNT_W  = $clog2(DW + 1);

   localparam logic signed [DW-1:0] DW_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] DW_MIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [IW-1:0] IW_MAX = {1'b0, {(IW-1){1'b1}}};
   localparam logic signed [IW-1:0] IW_MIN = {1'b1, {(IW-1){1'b0}}};

   // registers, state and item
   logic signed [DW-1:0] target_ff, target_in, kp_ff, kp_in, ki_ff, ki_in, kd_ff, kd_in;
   logic signed [DW-1:0] last_err_ff, last_err_in;
   logic signed [IW-1:0] integ_ff, integ_in;
   logic [TW-1:0]        last_time_ff, last_time_in;
   logic signed [DW-1:0] meas_ff, meas_in;
   logic [TW-1:0]        time_ff, time_in;

   // datapath
   logic signed [DW-1:0] err_ff, err_in;
   logic signed [TW:0]   dt_ff, dt_in;
   logic signed [DW:0]   der_ff, der_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic                 clip_ff, clip_in;

   // multiplier
   logic                 mbusy_ff, mbusy_in;
   logic [MCNT_W-1:0]    mcnt_ff, mcnt_in;
   logic [MW-1:0]        ma_ff, ma_in, mb_ff, mb_in;
   logic                 mneg_ff, mneg_in, mshift_ff, mshift_in;
   logic [PW-1:0]        mprod_ff, mprod_in;
   logic signed [XW-1:0] term_ff, term_in;
   logic                 tclip_ff, tclip_in;

   // divider
   logic                 dbusy_ff, dbusy_in;
   logic [DCNT_W-1:0]    dcnt_ff, dcnt_in;
   logic [DW-1:0]        dq_ff, dq_in;
   logic [TW-1:0]        dden_ff, dden_in, drem_ff, drem_in;
   logic                 dneg_ff, dneg_in;

   // sequencer and response
   logic [SW-1:0]        pc_ff, pc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0] rsp_drive_ff, rsp_drive_in, rsp_err_ff, rsp_err_in;
   logic                 rsp_sat_ff, rsp_sat_in;

   pidvs_pkg::ucode_type uw;
   logic                 jump;
   logic                 req_xfer, rsp_stall;

   logic signed [DW:0]   err_diff;
   logic signed [DW-1:0] err_sat;
   logic                 err_clip;
   logic signed [MW-1:0] op_a, op_b;
   logic                 op_shift;
   logic [MW-1:0]        op_a_mag, op_b_mag;
   logic [MW+GW-1:0]     mpart;
   logic [PW-1:0]        mshifted;
   logic                 mover;
   logic [XW-1:0]        tmag;
   logic signed [AW-1:0] term_ext, integ_sum;
   logic                 integ_ok;
   logic signed [DW:0]   num_diff;
   logic [DW:0]          num_mag;
   logic [TW:0]          dt_mag;
   logic [TW:0]          dtrial;
   logic                 dge;
   logic                 drive_ok;

   assign uw        = pidvs_pkg::ucode_rom(pc_ff);
   assign req_xfer  = req_bus.valid && (pc_ff == pidvs_pkg::STEP_IDLE);
   assign rsp_stall = rsp_valid_ff && !rsp_bus.ready;

   assign req_bus.ready          = (pc_ff == pidvs_pkg::STEP_IDLE);
   assign csr_bus.ready          = 1'b1;
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.drive_value    = rsp_drive_ff;
   assign rsp_bus.error_value    = rsp_err_ff;
   assign rsp_bus.saturated_flag = rsp_sat_ff;

   assign err_diff = {target_ff[DW-1], target_ff} - {meas_ff[DW-1], meas_ff};
   assign err_clip = (err_diff[DW] != err_diff[DW-1]);
   assign err_sat  = err_clip ? (err_diff[DW] ? DW_MIN : DW_MAX) : err_diff[DW-1:0];

   always_comb begin
      case (uw.op)
         pidvs_pkg::OP_MUL_P: begin
            op_a     = {{(MW-DW){kp_ff[DW-1]}}, kp_ff};
            op_b     = {{(MW-DW){err_ff[DW-1]}}, err_ff};
            op_shift = 1'b1;
         end
         pidvs_pkg::OP_MUL_I: begin
            op_a     = {{(MW-DW){err_ff[DW-1]}}, err_ff};
            op_b     = {{(MW-TW-1){dt_ff[TW]}}, dt_ff};
            op_shift = 1'b0;
         end
         pidvs_pkg::OP_MUL_G: begin
            op_a     = {{(MW-DW){ki_ff[DW-1]}}, ki_ff};
            op_b     = {{(MW-IW){integ_ff[IW-1]}}, integ_ff};
            op_shift = 1'b1;
         end
         pidvs_pkg::OP_MUL_D: begin
            op_a     = {{(MW-DW){kd_ff[DW-1]}}, kd_ff};
            op_b     = {{(MW-DW-1){der_ff[DW]}}, der_ff};
            op_shift = 1'b1;
         end
         default: begin
            op_a     = '0;
            op_b     = '0;
            op_shift = 1'b0;
         end
      endcase
   end

   assign op_a_mag = op_a[MW-1] ? MW'(-op_a) : MW'(op_a);
   assign op_b_mag = op_b[MW-1] ? MW'(-op_b) : MW'(op_b);

   assign mpart    = {{GW{1'b0}}, ma_ff} * {{MW{1'b0}}, mb_ff[MW-1 -: GW]};
   assign mshifted = mshift_ff ? (mprod_ff >> FRAC_BITS) : mprod_ff;
   assign mover    = (mshifted > pidvs_pkg::TERM_LIM);
   assign tmag     = mover ? pidvs_pkg::TERM_LIM[XW-1:0] : mshifted[XW-1:0];

   assign term_ext  = {{(AW-XW){term_ff[XW-1]}}, term_ff};
   assign integ_sum = {{(AW-IW){integ_ff[IW-1]}}, integ_ff} + term_ext;
   assign integ_ok  = (&integ_sum[AW-1:IW-1]) || !(|integ_sum[AW-1:IW-1]);

   assign num_diff = {err_ff[DW-1], err_ff} - {last_err_ff[DW-1], last_err_ff};
   assign num_mag  = num_diff[DW] ? (DW+1)'(-num_diff) : (DW+1)'(num_diff);
   assign dt_mag   = dt_ff[TW] ? (TW+1)'(-dt_ff) : (TW+1)'(dt_ff);
   assign dtrial   = {drem_ff, dq_ff[DW-1]};
   assign dge      = (dtrial >= {1'b0, dden_ff});

   assign drive_ok = (&acc_ff[AW-1:DW-1]) || !(|acc_ff[AW-1:DW-1]);

   always_comb begin
      case (uw.cond)
         pidvs_pkg::COND_NEVER:    jump = 1'b0;
         pidvs_pkg::COND_ALWAYS:   jump = 1'b1;
         pidvs_pkg::COND_NO_REQ:   jump = !req_bus.valid;
         pidvs_pkg::COND_MUL_BUSY: jump = mbusy_ff;
         pidvs_pkg::COND_DIV_BUSY: jump = dbusy_ff;
         pidvs_pkg::COND_DT_ZERO:  jump = (dt_ff == '0);
         pidvs_pkg::COND_RSP_BUSY: jump = rsp_stall;
         default:                  jump = 1'b0;
      endcase
   end

   always_comb begin
      target_in    = target_ff;
      kp_in        = kp_ff;
      ki_in        = ki_ff;
      kd_in        = kd_ff;
      last_err_in  = last_err_ff;
      integ_in     = integ_ff;
      last_time_in = last_time_ff;
      meas_in      = meas_ff;
      time_in      = time_ff;
      err_in       = err_ff;
      dt_in        = dt_ff;
      der_in       = der_ff;
      acc_in       = acc_ff;
      clip_in      = clip_ff;
      mbusy_in     = mbusy_ff;
      mcnt_in      = mcnt_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      mneg_in      = mneg_ff;
      mshift_in    = mshift_ff;
      mprod_in     = mprod_ff;
      term_in      = term_ff;
      tclip_in     = tclip_ff;
      dbusy_in     = dbusy_ff;
      dcnt_in      = dcnt_ff;
      dq_in        = dq_ff;
      dden_in      = dden_ff;
      drem_in      = drem_ff;
      dneg_in      = dneg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_sat_in   = rsp_sat_ff;
      pc_in        = jump ? uw.target : pc_ff + SW'(1);

      if (csr_bus.valid) begin
         case (csr_bus.index)
            pidvs_pkg::REG_TARGET:     target_in = csr_bus.data;
            pidvs_pkg::REG_GAIN_PROP:  kp_in     = csr_bus.data;
            pidvs_pkg::REG_GAIN_INTEG: ki_in     = csr_bus.data;
            pidvs_pkg::REG_GAIN_DERIV: kd_in     = csr_bus.data;
            default: ;
         endcase
      end

      if (req_xfer) begin
         meas_in = req_bus.measured_value;
         time_in = req_bus.sample_time;
      end

      // multiply one 16-bit digit per cycle, most significant first, then clamp
      if (mbusy_ff) begin
         if (mcnt_ff != '0) begin
            mprod_in = {mprod_ff[PW-GW-1:0], {GW{1'b0}}} + {{(PW-MW-GW){1'b0}}, mpart};
            mb_in    = {mb_ff[MW-GW-1:0], {GW{1'b0}}};
            mcnt_in  = mcnt_ff - MCNT_W'(1);
         end else begin
            term_in  = mneg_ff ? XW'(-tmag) : XW'(tmag);
            tclip_in = mover;
            mbusy_in = 1'b0;
         end
      end

      // restoring division, one quotient bit per cycle
      if (dbusy_ff) begin
         if (dcnt_ff != '0) begin
            drem_in = dge ? TW'(dtrial - {1'b0, dden_ff}) : dtrial[TW-1:0];
            dq_in   = {dq_ff[DW-2:0], dge};
            dcnt_in = dcnt_ff - DCNT_W'(1);
         end else begin
            der_in   = dneg_ff ? (DW+1)'(-{1'b0, dq_ff}) : {1'b0, dq_ff};
            dbusy_in = 1'b0;
         end
      end

      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (uw.op)
         pidvs_pkg::OP_ERR: begin
            err_in  = err_sat;
            clip_in = err_clip;
            dt_in   = {1'b0, time_ff} - {1'b0, last_time_ff};
         end
         pidvs_pkg::OP_MUL_P, pidvs_pkg::OP_MUL_I, pidvs_pkg::OP_MUL_G,
         pidvs_pkg::OP_MUL_D: begin
            mbusy_in  = 1'b1;
            mcnt_in   = MCNT_W'(pidvs_pkg::NUM_DIGITS);
            ma_in     = op_a_mag;
            mb_in     = op_b_mag;
            mneg_in   = op_a[MW-1] ^ op_b[MW-1];
            mshift_in = op_shift;
            mprod_in  = '0;
         end
         pidvs_pkg::OP_DIV: begin
            dbusy_in = 1'b1;
            dcnt_in  = DCNT_W'(DW);
            dq_in    = num_mag[DW-1:0];
            dden_in  = dt_mag[TW-1:0];
            drem_in  = '0;
            dneg_in  = num_diff[DW] ^ dt_ff[TW];
         end
         pidvs_pkg::OP_ACC_SET: begin
            acc_in  = term_ext;
            clip_in = clip_ff | tclip_ff;
         end
         pidvs_pkg::OP_ACC_ADD: begin
            acc_in  = acc_ff + term_ext;
            clip_in = clip_ff | tclip_ff;
         end
         pidvs_pkg::OP_INTEG: begin
            integ_in = integ_ok ? integ_sum[IW-1:0] : (integ_sum[AW-1] ? IW_MIN : IW_MAX);
            clip_in  = clip_ff | tclip_ff | !integ_ok;
         end
         pidvs_pkg::OP_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = drive_ok ? acc_ff[DW-1:0] : (acc_ff[AW-1] ? DW_MIN : DW_MAX);
               rsp_err_in   = err_ff;
               rsp_sat_in   = clip_ff | !drive_ok;
               last_err_in  = err_ff;
               last_time_in = time_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         kp_ff        <= '0;
         ki_ff        <= '0;
         kd_ff        <= '0;
         last_err_ff  <= '0;
         integ_ff     <= '0;
         last_time_ff <= '0;
         mbusy_ff     <= 1'b0;
         dbusy_ff     <= 1'b0;
         pc_ff        <= pidvs_pkg::STEP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         target_ff    <= target_in;
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
         last_err_ff  <= last_err_in;
         integ_ff     <= integ_in;
         last_time_ff <= last_time_in;
         mbusy_ff     <= mbusy_in;
         dbusy_ff     <= dbusy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      meas_ff      <= meas_in;
      time_ff      <= time_in;
      err_ff       <= err_in;
      dt_ff        <= dt_in;
      der_ff       <= der_in;
      acc_ff       <= acc_in;
      clip_ff      <= clip_in;
      mcnt_ff      <= mcnt_in;
      ma_ff        <= ma_in;
      mb_ff        <= mb_in;
      mneg_ff      <= mneg_in;
      mshift_ff    <= mshift_in;
      mprod_ff     <= mprod_in;
      term_ff      <= term_in;
      tclip_ff     <= tclip_in;
      dcnt_ff      <= dcnt_in;
      dq_ff        <= dq_in;
      dden_ff      <= dden_in;
      drem_ff      <= drem_in;
      dneg_ff      <= dneg_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the variable-step PID controller with a fixed-point predictor.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW = pidvs_pkg::DATA_WIDTH_DEF;
   localparam int FB = pidvs_pkg::FRAC_BITS_DEF;
   localparam int IW = pidvs_pkg::INTEG_W;
   localparam logic [127:0] PRODUCT_CAP = 128'd1 << 60;
   localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_MIN = 32'h8000_0000;
   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

   typedef struct packed {
      logic signed [DW-1:0] drive;
      logic signed [DW-1:0] error;
      logic                 clip;
   } pid_result_type;

   logic clock;
   logic reset;

   pidvs_req_if #(.DATA_WIDTH(DW)) req_bus ();
   pidvs_rsp_if #(.DATA_WIDTH(DW)) rsp_bus ();
   pidvs_csr_if #(.DATA_WIDTH(DW)) csr_bus ();

   pid_controller_variable_step #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   longint      cfg_target = 0;
   longint      cfg_kp = 0;
   longint      cfg_ki = 0;
   longint      cfg_kd = 0;
   longint      ctl_last_error = 0;
   longint      ctl_integral = 0;
   logic [31:0] ctl_last_time = '0;

   pid_result_type pending_outputs[$];
   int          mismatch_count = 0;
   int          snd_idle = 13;
   int          rcv_idle = 45;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic longint clamp_signed(input longint v, input int w, inout bit clip);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         clip = 1'b1;
         return hi;
      end
      if (v < lo) begin
         clip = 1'b1;
         return lo;
      end
      return v;
   endfunction

   // exact product of magnitudes, shifted, truncated toward zero, capped at 2^60
   function automatic longint scaled_product(input longint a, input longint b, input int sh,
                                             inout bit clip);
      logic [63:0]  ua;
      logic [63:0]  ub;
      logic [127:0] p;
      bit           neg;
      ua  = (a < 0) ? -a : a;
      ub  = (b < 0) ? -b : b;
      neg = (a < 0) != (b < 0);
      p   = {64'd0, ua} * {64'd0, ub};
      p   = p >> sh;
      if (p > PRODUCT_CAP) begin
         clip = 1'b1;
         p    = PRODUCT_CAP;
      end
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
   endfunction

   function automatic pid_result_type advance_pid_model(input logic signed [DW-1:0] meas,
                                                        input logic [31:0] stamp);
      pid_result_type r;
      bit          clip;
      longint      err;
      longint      drive;
      longint      dt;
      longint      der;
      longint      inc;
      clip  = 1'b0;
      err   = clamp_signed(cfg_target - longint'(meas), DW, clip);
      drive = scaled_product(cfg_kp, err, FB, clip);
      dt    = longint'({32'd0, stamp}) - longint'({32'd0, ctl_last_time});
      if (dt != 0) begin
         der          = (err - ctl_last_error) / dt;
         inc          = scaled_product(err, dt, 0, clip);
         ctl_integral = clamp_signed(ctl_integral + inc, IW, clip);
         drive        = drive + scaled_product(cfg_kd, der, FB, clip);
         drive        = drive + scaled_product(cfg_ki, ctl_integral, FB, clip);
      end
      drive          = clamp_signed(drive, DW, clip);
      ctl_last_error = err;
      ctl_last_time  = stamp;
      r.drive = drive[DW-1:0];
      r.error = err[DW-1:0];
      r.clip  = clip;
      return r;
   endfunction

   always @(posedge clock) begin
      pid_result_type want;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               pidvs_pkg::REG_TARGET:     cfg_target = longint'(csr_bus.data);
               pidvs_pkg::REG_GAIN_PROP:  cfg_kp = longint'(csr_bus.data);
               pidvs_pkg::REG_GAIN_INTEG: cfg_ki = longint'(csr_bus.data);
               pidvs_pkg::REG_GAIN_DERIV: cfg_kd = longint'(csr_bus.data);
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            pending_outputs.push_back(
               advance_pid_model(req_bus.measured_value, req_bus.sample_time));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_outputs.size() == 0) begin
               $error("response with none pending: drive_value %0d error_value %0d",
                      rsp_bus.drive_value, rsp_bus.error_value);
               mismatch_count++;
            end else begin
               want = pending_outputs.pop_front();
               if (rsp_bus.drive_value !== want.drive) begin
                  $error("drive_value: expected %0d, got %0d", want.drive,
                         rsp_bus.drive_value);
                  mismatch_count++;
               end
               if (rsp_bus.error_value !== want.error) begin
                  $error("error_value: expected %0d, got %0d", want.error,
                         rsp_bus.error_value);
                  mismatch_count++;
               end
               if (rsp_bus.saturated_flag !== want.clip) begin
                  $error("saturated_flag: expected %0b, got %0b", want.clip,
                         rsp_bus.saturated_flag);
                  mismatch_count++;
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready = ($urandom_range(0, 99) >= rcv_idle);
   end

   task automatic send_sample(input logic [31:0] meas, input logic [31:0] stamp);
      @(negedge clock);
      while ($urandom_range(0, 99) < snd_idle) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid          = 1'b1;
      req_bus.measured_value = meas;
      req_bus.sample_time    = stamp;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [pidvs_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] value);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = value;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic load_gains(input logic [31:0] tgt, input logic [31:0] kp,
                             input logic [31:0] ki, input logic [31:0] kd);
      wait_idle();
      write_reg(pidvs_pkg::REG_TARGET, tgt);
      write_reg(pidvs_pkg::REG_GAIN_PROP, kp);
      write_reg(pidvs_pkg::REG_GAIN_INTEG, ki);
      write_reg(pidvs_pkg::REG_GAIN_DERIV, kd);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   function automatic logic [31:0] pick_reg_value();
      case ($urandom_range(0, 7))
         0:       return POS_MAX;
         1:       return NEG_MIN;
         2:       return '0;
         3, 4:    return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
         5:       return 32'($urandom_range(0, 1 << 24)) - 32'(1 << 23);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_after_reset();
      send_sample(32'd0, 32'd0);
      send_sample(NEG_MIN, 32'd3);
      send_sample(POS_MAX, 32'd3);
   endtask

   task automatic test_extremes();
      load_gains(POS_MAX, POS_MAX, POS_MAX, POS_MAX);
      send_sample(NEG_MIN, 32'd10);
      send_sample(POS_MAX, 32'd20);
      send_sample(32'd0, 32'd20);
      load_gains(NEG_MIN, NEG_MIN, NEG_MIN, NEG_MIN);
      send_sample(POS_MAX, 32'hFFFF_FFFF);
      send_sample(NEG_MIN, 32'd0);
      send_sample(32'd0, 32'd1);
   endtask

   task automatic test_time_steps();
      load_gains(ONE_Q16, ONE_Q16, 32'h0000_8000, 32'h0000_4000);
      send_sample(32'd0, 32'd5);
      send_sample(32'h0000_8000, 32'd5);
      send_sample(32'h0000_8000, 32'd5);
      send_sample(32'hFFFF_0000, 32'd2);
      send_sample(32'h0002_0000, 32'd3);
      send_sample(32'h0001_0000, 32'hFFFF_FFFF);
      send_sample(32'hFFF0_0000, 32'd0);
      send_sample(32'h0003_0000, 32'd7);
   endtask

   task automatic test_random_traffic(input int snd_pct, input int rcv_pct);
      logic [31:0] tgt;
      logic [31:0] meas;
      logic [31:0] stamp;
      stamp = ctl_last_time;
      repeat (4) begin
         tgt = pick_reg_value();
         load_gains(tgt, pick_reg_value(), pick_reg_value(), pick_reg_value());
         snd_idle = snd_pct;
         rcv_idle = rcv_pct;
         repeat (96) begin
            case ($urandom_range(0, 19))
               0:       ;
               1:       stamp = stamp - 32'($urandom_range(1, 1000));
               2:       stamp = $urandom;
               3:       stamp = stamp + 32'($urandom_range(1 << 16, 1 << 30));
               default: stamp = stamp + 32'($urandom_range(1, 64));
            endcase
            case ($urandom_range(0, 9))
               0:       meas = POS_MAX;
               1:       meas = NEG_MIN;
               2, 3:    meas = $urandom;
               default: meas = tgt + 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
            endcase
            send_sample(meas, stamp);
         end
      end
   endtask

   initial begin
      int guard;
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.measured_value = '0;
      req_bus.sample_time    = '0;
      rsp_bus.ready          = 1'b0;
      csr_bus.valid          = 1'b0;
      csr_bus.index          = pidvs_pkg::REG_TARGET;
      csr_bus.data           = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_after_reset();
      test_extremes();
      test_time_steps();
      test_random_traffic(13, 45);
      test_random_traffic(45, 13);
      test_random_traffic(0, 0);

      @(negedge clock);
      req_bus.valid = 1'b0;
      guard = 0;
      while (pending_outputs.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (80) @(posedge clock);
      if (pending_outputs.size() != 0) begin
         $error("%0d responses never arrived", pending_outputs.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
hw/rtl/pidvs_pkg.sv
hw/rtl/pidvs_if.sv
hw/rtl/pid_controller_variable_step.sv
tb/tb.sv
